@@ rtl/core/fsf_pkg.sv @@
// Package: types, constants and codes of the FASTQ/SAM record framer.
`default_nettype none
package fsf_pkg;

  localparam int unsigned COUNT_BITS = 32;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  typedef logic [COUNT_BITS-1:0] count_t;
  localparam count_t COUNT_MAX = '1;

  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_PLUS = 8'h2B;

  localparam logic [APB_ADDR_W-3:0] REG_FORMAT_MODE = '0;

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_HEAD    = 3'd1,
    PH_SEQ_BOL = 3'd2,
    PH_SEQ_MID = 3'd3,
    PH_SPACER  = 3'd4,
    PH_QUAL    = 3'd5,
    PH_SAM_MID = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_END   = 2'd1,
    ST_TRUNC = 2'd2,
    ST_OVF   = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       record_end;
    status_e    status;
  } out_item_t;

endpackage
`default_nettype wire

@@ rtl/core/fsf_if.sv @@
// Interfaces: valid/ready channels for input bytes and framed result items.
`default_nettype none
interface fsf_in_if;
  logic              valid;
  logic              ready;
  fsf_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fsf_out_if;
  logic               valid;
  logic               ready;
  fsf_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/fastq_sam_record_framer.sv @@
// Top level: FASTQ/SAM record framer with APB configuration port.
// The result transaction is presented in the cycle after its input transaction is accepted.
// Throughput: one byte per cycle; input ready is high while the output register is
// empty or its transaction is taken in the same cycle.
// Reset: phase to record start, section count to zero, format_mode to FASTQ,
// output register empty.
`default_nettype none
module fastq_sam_record_framer (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  fsf_in_if.sink                               in_i,
  fsf_out_if.source                            out_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [fsf_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [fsf_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [fsf_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                 pready
);

  fsf_pkg::phase_e    phase_q, phase_d;
  fsf_pkg::count_t    count_q, count_d;
  logic               mode_q, mode_d;
  logic               out_valid_q, out_valid_d;
  fsf_pkg::out_item_t out_data_q, out_data_d;

  logic in_acc;
  logic cfg_wr;
  logic reg_sel;
  logic nl;
  fsf_pkg::count_t count_dec;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[fsf_pkg::APB_ADDR_W-1:2] == fsf_pkg::REG_FORMAT_MODE);
  assign cfg_wr  = psel && penable && pwrite && reg_sel;
  assign prdata  = reg_sel ? {{(fsf_pkg::APB_DATA_W-1){1'b0}}, mode_q} : '0;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  assign nl        = (in_i.data.data_byte == fsf_pkg::CH_NL);
  assign count_dec = (count_q != '0) ? count_q - fsf_pkg::count_t'(1) : '0;

  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    mode_d      = mode_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;

    if (in_acc) begin
      out_valid_d           = 1'b1;
      out_data_d.out_byte   = in_i.data.data_byte;
      out_data_d.record_end = 1'b0;
      out_data_d.status     = fsf_pkg::ST_OK;
      if (in_i.data.end_of_input) begin
        out_data_d.out_byte = '0;
        out_data_d.status   = (phase_q == fsf_pkg::PH_START || phase_q > fsf_pkg::PH_SAM_MID) ?
                              fsf_pkg::ST_END : fsf_pkg::ST_TRUNC;
        phase_d = fsf_pkg::PH_START;
        count_d = '0;
      end else if (mode_q) begin
        if (nl) begin
          out_data_d.record_end = 1'b1;
          phase_d = fsf_pkg::PH_START;
        end else begin
          phase_d = fsf_pkg::PH_SAM_MID;
        end
      end else begin
        unique case (phase_q)
          fsf_pkg::PH_SEQ_BOL, fsf_pkg::PH_SEQ_MID: begin
            if (phase_q == fsf_pkg::PH_SEQ_BOL && in_i.data.data_byte == fsf_pkg::CH_PLUS) begin
              phase_d = fsf_pkg::PH_SPACER;
            end else begin
              if (count_q == fsf_pkg::COUNT_MAX) begin
                out_data_d.status = fsf_pkg::ST_OVF;
              end else begin
                count_d = count_q + fsf_pkg::count_t'(1);
              end
              phase_d = nl ? fsf_pkg::PH_SEQ_BOL : fsf_pkg::PH_SEQ_MID;
            end
          end
          fsf_pkg::PH_SPACER: begin
            if (nl) begin
              if (count_q == '0) begin
                out_data_d.record_end = 1'b1;
                phase_d = fsf_pkg::PH_START;
              end else begin
                phase_d = fsf_pkg::PH_QUAL;
              end
            end
          end
          fsf_pkg::PH_QUAL: begin
            count_d = count_dec;
            if (count_dec == '0) begin
              out_data_d.record_end = 1'b1;
              phase_d = fsf_pkg::PH_START;
            end
          end
          fsf_pkg::PH_SAM_MID: begin
            phase_d = nl ? fsf_pkg::PH_SEQ_BOL : fsf_pkg::PH_HEAD;
            count_d = '0;
          end
          default: begin
            if (nl) begin
              phase_d = fsf_pkg::PH_SEQ_BOL;
              count_d = '0;
            end else begin
              phase_d = fsf_pkg::PH_HEAD;
            end
          end
        endcase
      end
    end

    if (cfg_wr) begin
      mode_d  = pwdata[0];
      phase_d = fsf_pkg::PH_START;
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= fsf_pkg::PH_START;
      count_q     <= '0;
      mode_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      count_q     <= count_d;
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  a_rend_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.record_end |-> out_data_q.status == fsf_pkg::ST_OK)
    else $error("record end marked with non-ok status");

  a_eoi_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.data.end_of_input |=> phase_q == fsf_pkg::PH_START && count_q == '0)
    else $error("state not cleared after end of input");

  a_qual_owes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == fsf_pkg::PH_QUAL |-> count_q != '0)
    else $error("quality phase with nothing owed");

  a_end_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_data_q.status == fsf_pkg::ST_END ||
                    out_data_q.status == fsf_pkg::ST_TRUNC)
    |-> out_data_q.out_byte == '0 && !out_data_q.record_end)
    else $error("end-of-input result carries a byte");

endmodule
`default_nettype wire

@@ test/fsf_framer_checker.sv @@
// Checker: predicts the framed byte stream of the record framer and compares transactions.
`timescale 1ns / 1ps
module fsf_framer_checker
  import fsf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  fsf_in_if                     in_i,
  fsf_out_if                    out_i,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic [APB_DATA_W-1:0] prdata,
  input  logic                  pready,
  output int unsigned           errors_o,
  output int unsigned           pending_o
);

  logic        sam_mode;
  phase_e      phase_q;
  count_t      seq_count;
  out_item_t   framed_q[$];
  int unsigned mismatches = 0;
  int unsigned waiting = 0;

  assign errors_o  = mismatches;
  assign pending_o = waiting;

  task automatic report_mismatch(input string msg);
    if (mismatches < 40) begin
      $display("%0t checker: %s", $time, msg);
    end
    mismatches++;
  endtask

  function automatic out_item_t frame_byte(input in_item_t item);
    out_item_t res;
    logic      nl;
    res.out_byte   = item.data_byte;
    res.record_end = 1'b0;
    res.status     = ST_OK;
    nl             = (item.data_byte == CH_NL);
    if (item.end_of_input) begin
      res.out_byte = '0;
      if (phase_q == PH_START) begin
        res.status = ST_END;
      end else begin
        res.status = ST_TRUNC;
      end
      phase_q   = PH_START;
      seq_count = '0;
    end else if (sam_mode) begin
      res.record_end = nl;
      phase_q        = nl ? PH_START : PH_SAM_MID;
    end else begin
      case (phase_q)
        PH_START, PH_HEAD: begin
          if (nl) begin
            phase_q   = PH_SEQ_BOL;
            seq_count = '0;
          end else begin
            phase_q = PH_HEAD;
          end
        end
        PH_SEQ_BOL, PH_SEQ_MID: begin
          if (phase_q == PH_SEQ_BOL && item.data_byte == CH_PLUS) begin
            phase_q = PH_SPACER;
          end else begin
            if (seq_count == COUNT_MAX) begin
              res.status = ST_OVF;
            end else begin
              seq_count = seq_count + count_t'(1);
            end
            phase_q = nl ? PH_SEQ_BOL : PH_SEQ_MID;
          end
        end
        PH_SPACER: begin
          if (nl) begin
            if (seq_count == '0) begin
              res.record_end = 1'b1;
              phase_q        = PH_START;
            end else begin
              phase_q = PH_QUAL;
            end
          end
        end
        PH_QUAL: begin
          if (seq_count != '0) begin
            seq_count = seq_count - count_t'(1);
          end
          if (seq_count == '0) begin
            res.record_end = 1'b1;
            phase_q        = PH_START;
          end
        end
        default: begin
          // SAM mid-line left over in FASTQ mode: restart as a header
          phase_q   = nl ? PH_SEQ_BOL : PH_HEAD;
          seq_count = '0;
        end
      endcase
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    out_item_t got;
    if (!rst_ni) begin
      sam_mode  = 1'b0;
      phase_q   = PH_START;
      seq_count = '0;
      framed_q.delete();
    end else begin
      if (out_i.valid && out_i.ready) begin
        got = out_i.data;
        if (framed_q.size() == 0) begin
          report_mismatch($sformatf("result byte %0h with nothing expected", got.out_byte));
        end else begin
          want = framed_q.pop_front();
          if (got.out_byte !== want.out_byte) begin
            report_mismatch($sformatf("out_byte got %0h want %0h",
                                      got.out_byte, want.out_byte));
          end
          if (got.record_end !== want.record_end) begin
            report_mismatch($sformatf("record_end got %0b want %0b on byte %0h",
                                      got.record_end, want.record_end, want.out_byte));
          end
          if (got.status !== want.status) begin
            report_mismatch($sformatf("status got %0d want %0d on byte %0h",
                                      got.status, want.status, want.out_byte));
          end
        end
      end
      if (in_i.valid && in_i.ready) begin
        framed_q.push_back(frame_byte(in_i.data));
      end
      if (psel && penable && pready && paddr[APB_ADDR_W-1:2] == REG_FORMAT_MODE) begin
        if (pwrite) begin
          sam_mode  = pwdata[0];
          phase_q   = PH_START;
          seq_count = '0;
        end else if (prdata !== APB_DATA_W'(sam_mode)) begin
          report_mismatch($sformatf("format_mode read %0h want %0h", prdata, sam_mode));
        end
      end
    end
    waiting = framed_q.size();
  end

endmodule

@@ test/tb.sv @@
// Testbench top: drives text streams, APB writes and output stalls, and gives the verdict.
`timescale 1ns / 1ps
module tb;
  import fsf_pkg::*;

  typedef logic [7:0] text_t[$];

  localparam logic [7:0]            CH_AT            = 8'h40;
  localparam logic [APB_ADDR_W-1:0] ADDR_FORMAT_MODE = {REG_FORMAT_MODE, 2'b00};
  localparam logic [APB_ADDR_W-1:0] ADDR_SPARE       = {~REG_FORMAT_MODE, 2'b00};
  localparam int unsigned           RX_HOLD_CYCLES   = 300;
  localparam int unsigned           PHASES           = 8;
  localparam int unsigned           PHASE_ITEMS      = 178;

  logic                  clk_i   = 1'b0;
  logic                  rst_ni  = 1'b0;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  int unsigned           errors;
  int unsigned           pending;
  int unsigned           sent        = 0;
  int unsigned           rx_gap      = 0;
  logic                  rx_hold_req = 1'b0;
  logic                  no_idle     = 1'b0;

  fsf_in_if  in_ch ();
  fsf_out_if out_ch ();

  fastq_sam_record_framer dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  fsf_framer_checker u_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_ch),
    .out_i     (out_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .errors_o  (errors),
    .pending_o (pending)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 65) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 254));
    if (b >= CH_NL) begin
      b++;
    end
    return b;
  endfunction

  function automatic logic [7:0] lead_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 253));
    if (b >= CH_NL) begin
      b++;
    end
    if (b >= CH_PLUS) begin
      b++;
    end
    return b;
  endfunction

  function automatic logic [7:0] noise_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      return CH_NL;
    end
    if (r < 40) begin
      return CH_PLUS;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic text_t fastq_record();
    text_t       t;
    int unsigned len;
    int unsigned owed;
    owed = 0;
    if ($urandom_range(0, 7) != 0) begin
      t.push_back(CH_AT);
      repeat ($urandom_range(0, 6)) t.push_back(plain_byte());
    end
    t.push_back(CH_NL);
    repeat ($urandom_range(0, 3)) begin
      len = $urandom_range(0, 8);
      for (int i = 0; i < len; i++) begin
        t.push_back(i == 0 ? lead_byte() : plain_byte());
      end
      t.push_back(CH_NL);
      owed += len + 1;
    end
    t.push_back(CH_PLUS);
    repeat ($urandom_range(0, 3)) t.push_back(plain_byte());
    t.push_back(CH_NL);
    repeat (owed) t.push_back(8'($urandom_range(0, 255)));
    return t;
  endfunction

  function automatic text_t sam_line();
    text_t t;
    repeat ($urandom_range(0, 12)) t.push_back(plain_byte());
    t.push_back(CH_NL);
    return t;
  endfunction

  task automatic send_item(input logic [7:0] b, input logic eoi);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid = 1'b1;
    in_ch.data  = in_item_t'{data_byte: b, end_of_input: eoi};
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
    sent++;
  endtask

  task automatic send_eoi();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_text(input text_t t, input int unsigned n);
    for (int i = 0; i < n; i++) begin
      send_item(t[i], 1'b0);
    end
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    wait (pending == 0);
    @(negedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = addr;
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic configure(input logic mode);
    logic [APB_DATA_W-1:0] value;
    drain();
    value    = $urandom();
    value[0] = mode;
    apb_access(1'b1, ADDR_FORMAT_MODE, value);
    apb_access(1'b0, ADDR_FORMAT_MODE, '0);
  endtask

  task automatic at_posedge_set(input logic quiet, input logic hold);
    @(posedge clk_i);
    no_idle = quiet;
    if (hold) begin
      rx_hold_req = 1'b1;
    end
    @(negedge clk_i);
  endtask

  task automatic run_phase(input logic mode, input int unsigned quota);
    text_t       t;
    int unsigned r;
    int unsigned stop;
    stop = sent + quota;
    while (sent < stop) begin
      r = $urandom_range(0, 99);
      t = mode ? sam_line() : fastq_record();
      if (r < 78) begin
        send_text(t, t.size());
      end else if (r < 90) begin
        send_text(t, t.size() > 1 ? $urandom_range(1, t.size() - 1) : 0);
        send_eoi();
      end else begin
        repeat ($urandom_range(1, 12)) send_item(noise_byte(), 1'b0);
        if ($urandom_range(0, 1) != 0) begin
          send_eoi();
        end
      end
      if ($urandom_range(0, 15) == 0) begin
        send_eoi();
      end
    end
  endtask

  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req  = 1'b0;
        out_ch.ready = 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk_i);
      end
      if (rx_gap != 0) begin
        out_ch.ready = 1'b0;
        rx_gap--;
      end else begin
        out_ch.ready = 1'b1;
        rx_gap       = pick_gap();
      end
    end
  end

  initial begin
    text_t t;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    configure(1'b0);
    t = {CH_NL, CH_PLUS, CH_NL, CH_AT, 8'hFF, CH_NL, 8'h41, CH_NL, CH_NL};
    send_text(t, t.size());
    // hold the record open across a write to an unmapped register
    drain();
    apb_access(1'b1, ADDR_SPARE, 32'hFFFF_FFFF);
    t = {CH_PLUS, 8'h78, CH_NL, 8'h00, CH_NL, CH_PLUS};
    send_text(t, t.size());
    send_eoi();
    send_item(CH_AT, 1'b0);
    send_eoi();

    configure(1'b1);
    t = {8'h61, 8'h62, CH_NL, CH_NL, 8'h7A};
    send_text(t, t.size());
    send_eoi();
    send_eoi();

    for (int p = 0; p < PHASES; p++) begin
      configure(p[0]);
      at_posedge_set(p == 3 || p == 6, p == 2);
      run_phase(p[0], PHASE_ITEMS);
    end

    drain();
    repeat (4) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
